// ===== hw/rtl/priority_ready_queue_top_macros.svh =====
// assertion macros for the priority ready queue
// used at the end of priority_ready_queue_top, expects i_clk and i_rst_n in scope
`ifndef PRIORITY_READY_QUEUE_TOP_MACROS_SVH
`define PRIORITY_READY_QUEUE_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define PRQ_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("priority ready queue check failed");

// consequent holds in the same cycle as the antecedent
`define PRQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("priority ready queue check failed");

`endif

// ===== hw/rtl/prq_pkg.sv =====
// shared types and constants of the priority ready queue
// used by prq_cell and priority_ready_queue_top, no dependencies
package prq_pkg;

    localparam int CMD_BITS        = 2;
    localparam int ID_PORT_BITS    = 8;
    localparam int PRIO_PORT_BITS  = 8;
    localparam int COUNT_PORT_BITS = 5;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd2;

    // how a traveling token decides where it lands
    typedef enum logic [1:0] {
        MODE_APPEND   = 2'd0,
        MODE_PRIORITY = 2'd1,
        MODE_PUSH     = 2'd2
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
    } t_token;

endpackage

// ===== hw/rtl/prq_cell.sv =====
// one slot of the queue row: holds an entry and passes a token to the next slot
// depends on prq_pkg
module prq_cell #(
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pop,
    input  prq_pkg::t_token                 i_token,
    input  logic [ID_BITS-1:0]              i_tok_id,
    input  logic signed [PRIORITY_BITS-1:0] i_tok_prio,
    output prq_pkg::t_token                 o_token,
    output logic [ID_BITS-1:0]              o_tok_id,
    output logic signed [PRIORITY_BITS-1:0] o_tok_prio,
    input  logic                            i_next_occ,
    input  logic [ID_BITS-1:0]              i_next_id,
    input  logic signed [PRIORITY_BITS-1:0] i_next_prio,
    output logic                            o_occ,
    output logic [ID_BITS-1:0]              o_id,
    output logic signed [PRIORITY_BITS-1:0] o_prio,
    output logic                            o_busy
);
    import prq_pkg::*;

    t_token                          r_tok;
    logic [ID_BITS-1:0]              r_tok_id;
    logic signed [PRIORITY_BITS-1:0] r_tok_prio;
    logic                            r_occ;
    logic [ID_BITS-1:0]              r_id;
    logic signed [PRIORITY_BITS-1:0] r_prio;

    logic                            n_occ;
    logic [ID_BITS-1:0]              n_id;
    logic signed [PRIORITY_BITS-1:0] n_prio;
    logic                            stop;

    // token lands here: empty slot, pushing, or priority order or a matching id says so
    assign stop = r_tok.valid && (!r_occ || (r_tok.mode == MODE_PUSH) ||
                  ((r_tok.mode == MODE_PRIORITY) &&
                   ((r_prio > r_tok_prio) || (r_id == r_tok_id))));

    always_comb begin
        n_occ      = r_occ;
        n_id       = r_id;
        n_prio     = r_prio;
        o_token    = '{valid: 1'b0, mode: MODE_PUSH};
        o_tok_id   = r_tok_id;
        o_tok_prio = r_tok_prio;
        if (i_pop) begin
            n_occ  = i_next_occ;
            n_id   = i_next_id;
            n_prio = i_next_prio;
        end else if (stop) begin
            n_occ      = 1'b1;
            n_id       = r_tok_id;
            n_prio     = r_tok_prio;
            // displaced entry moves on one slot per cycle
            o_token    = '{valid: r_occ, mode: MODE_PUSH};
            o_tok_id   = r_id;
            o_tok_prio = r_prio;
        end else if (r_tok.valid) begin
            o_token = r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_tok.mode  <= MODE_PUSH;
            r_occ       <= 1'b0;
        end else begin
            r_tok <= i_token;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_id   <= i_tok_id;
        r_tok_prio <= i_tok_prio;
        r_id       <= n_id;
        r_prio     <= n_prio;
    end

    assign o_occ  = r_occ;
    assign o_id   = r_id;
    assign o_prio = r_prio;
    assign o_busy = r_tok.valid;

endmodule

// ===== hw/rtl/priority_ready_queue_top.sv =====
// priority ready queue: a row of QUEUE_DEPTH slots, head at slot 0
// result is registered in the cycle after accept; pop, unused and dropped full commands start no token,
// so they do not hold off the next accept; append and insert hold it off until their entry token and
// any entry it displaces have landed, rippling down the slot row one slot per cycle
// a result item waiting on the output blocks the next accept
// synchronous active-low reset empties the queue and clears the output valid
module priority_ready_queue_top #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic [prq_pkg::CMD_BITS-1:0]              i_cmd,
    input  logic [prq_pkg::ID_PORT_BITS-1:0]          i_thread_id,
    input  logic signed [prq_pkg::PRIO_PORT_BITS-1:0] i_priority_req,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic                                      o_pop_valid,
    output logic [prq_pkg::ID_PORT_BITS-1:0]          o_popped_id,
    output logic signed [prq_pkg::PRIO_PORT_BITS-1:0] o_popped_priority,
    output logic [prq_pkg::COUNT_PORT_BITS-1:0]       o_entry_count,
    output logic                                      o_overflow
);
    import prq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token                          tok_arr  [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]              tid_arr  [0:QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] tpr_arr  [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]              id_arr   [0:QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] prio_arr [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]            occ_vec;
    logic [QUEUE_DEPTH-1:0]          busy_vec;

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic                            r_out_valid;
    logic                            r_pop_valid;
    logic [ID_PORT_BITS-1:0]         r_popped_id;
    logic signed [PRIO_PORT_BITS-1:0] r_popped_prio;
    logic [COUNT_PORT_BITS-1:0]      r_entry_count;
    logic                            r_overflow;

    logic                            busy;
    logic                            accept;
    logic                            full;
    logic                            pop_go;
    t_token                          tok_in;
    logic                            res_pop_valid;
    logic [ID_PORT_BITS-1:0]         res_id;
    logic signed [PRIO_PORT_BITS-1:0] res_prio;
    logic                            res_ovf;

    assign busy       = |busy_vec;
    assign o_in_ready = !busy && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(QUEUE_DEPTH));

    // past the tail the row reads as empty
    assign occ_vec[QUEUE_DEPTH]  = 1'b0;
    assign id_arr[QUEUE_DEPTH]   = '0;
    assign prio_arr[QUEUE_DEPTH] = '0;
    assign tok_arr[0]            = tok_in;
    assign tid_arr[0]            = ID_BITS'(i_thread_id);
    assign tpr_arr[0]            = PRIORITY_BITS'(i_priority_req);

    always_comb begin
        n_count       = r_count;
        pop_go        = 1'b0;
        res_pop_valid = 1'b0;
        res_id        = '0;
        res_prio      = '0;
        res_ovf       = 1'b0;
        tok_in        = '{valid: 1'b0, mode: MODE_APPEND};
        if (accept) begin
            unique case (i_cmd) inside
                CMD_APPEND, CMD_INSERT: begin
                    if (full) begin
                        res_ovf = 1'b1;
                    end else begin
                        tok_in  = '{valid: 1'b1,
                                    mode: (i_cmd == CMD_APPEND) ? MODE_APPEND
                                                                : MODE_PRIORITY};
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (r_count != '0) begin
                        pop_go        = 1'b1;
                        res_pop_valid = 1'b1;
                        res_id        = ID_PORT_BITS'(id_arr[0]);
                        res_prio      = PRIO_PORT_BITS'(prio_arr[0]);
                        n_count       = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        prq_cell #(
            .ID_BITS       (ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pop       (pop_go),
            .i_token     (tok_arr[g]),
            .i_tok_id    (tid_arr[g]),
            .i_tok_prio  (tpr_arr[g]),
            .o_token     (tok_arr[g+1]),
            .o_tok_id    (tid_arr[g+1]),
            .o_tok_prio  (tpr_arr[g+1]),
            .i_next_occ  (occ_vec[g+1]),
            .i_next_id   (id_arr[g+1]),
            .i_next_prio (prio_arr[g+1]),
            .o_occ       (occ_vec[g]),
            .o_id        (id_arr[g]),
            .o_prio      (prio_arr[g]),
            .o_busy      (busy_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_valid   <= res_pop_valid;
            r_popped_id   <= res_id;
            r_popped_prio <= res_prio;
            r_entry_count <= COUNT_PORT_BITS'(n_count);
            r_overflow    <= res_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pop_valid       = r_pop_valid;
    assign o_popped_id       = r_popped_id;
    assign o_popped_priority = r_popped_prio;
    assign o_entry_count     = r_entry_count;
    assign o_overflow        = r_overflow;

`include "priority_ready_queue_top_macros.svh"

    // a token always lands before running past the last slot
    `PRQ_ASSERT_HOLDS(a_token_stays_in_row, !tok_arr[QUEUE_DEPTH].valid)
    // occupied slots form one run starting at the head
    `PRQ_ASSERT_HOLDS(a_occupancy_contiguous, ((occ_vec >> 1) & ~occ_vec) == '0)
    // once the row is settled the count agrees with the slots
    `PRQ_ASSERT_IMPLIES(a_count_matches_row, !busy, CW'($countones(occ_vec)) == r_count)

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for priority_ready_queue_top
// keeps its own copy of the ready queue and checks every result item in order
// depends on prq_pkg and the priority_ready_queue_top rtl
`timescale 1ns / 100ps

module testbench;
    import prq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int TOTAL_ITEMS = 1150;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                             pop_valid;
        logic [ID_PORT_BITS-1:0]          popped_id;
        logic signed [PRIO_PORT_BITS-1:0] popped_priority;
        logic [COUNT_PORT_BITS-1:0]       entry_count;
        logic                             overflow;
    } t_queue_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [CMD_BITS-1:0]              i_cmd;
    logic [ID_PORT_BITS-1:0]          i_thread_id;
    logic signed [PRIO_PORT_BITS-1:0] i_priority_req;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic                             o_pop_valid;
    logic [ID_PORT_BITS-1:0]          o_popped_id;
    logic signed [PRIO_PORT_BITS-1:0] o_popped_priority;
    logic [COUNT_PORT_BITS-1:0]       o_entry_count;
    logic                             o_overflow;

    priority_ready_queue_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_thread_id      (i_thread_id),
        .i_priority_req   (i_priority_req),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pop_valid      (o_pop_valid),
        .o_popped_id      (o_popped_id),
        .o_popped_priority(o_popped_priority),
        .o_entry_count    (o_entry_count),
        .o_overflow       (o_overflow)
    );

    // shadow copy of the ready queue, head at index 0
    logic [ID_PORT_BITS-1:0]          ready_ids [DEPTH];
    logic signed [PRIO_PORT_BITS-1:0] ready_prios [DEPTH];
    int                               ready_fill;

    t_queue_result pending_results[$];
    int            mismatches;
    int            items_sent;
    bit            idle_off;
    int            hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_queue_result queue_step(logic [CMD_BITS-1:0] cmd,
                                                 logic [ID_PORT_BITS-1:0] id,
                                                 logic signed [PRIO_PORT_BITS-1:0] prio);
        t_queue_result r;
        int            pos;
        r = '0;
        if (cmd == CMD_APPEND || cmd == CMD_INSERT) begin
            if (ready_fill >= DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                pos = ready_fill;
                if (cmd == CMD_INSERT) begin
                    // lands before the first later-served entry or a copy of its own id
                    for (int i = 0; i < ready_fill; i++) begin
                        if (ready_prios[i] > prio || ready_ids[i] == id) begin
                            pos = i;
                            break;
                        end
                    end
                end
                for (int i = ready_fill; i > pos; i--) begin
                    ready_ids[i]   = ready_ids[i-1];
                    ready_prios[i] = ready_prios[i-1];
                end
                ready_ids[pos]   = id;
                ready_prios[pos] = prio;
                ready_fill++;
            end
        end else if (cmd == CMD_POP) begin
            if (ready_fill > 0) begin
                r.pop_valid       = 1'b1;
                r.popped_id       = ready_ids[0];
                r.popped_priority = ready_prios[0];
                for (int i = 1; i < ready_fill; i++) begin
                    ready_ids[i-1]   = ready_ids[i];
                    ready_prios[i-1] = ready_prios[i];
                end
                ready_fill--;
            end
        end
        r.entry_count = ready_fill[COUNT_PORT_BITS-1:0];
        return r;
    endfunction

    task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [ID_PORT_BITS-1:0] id,
                             logic signed [PRIO_PORT_BITS-1:0] prio);
        int gap;
        if (!idle_off && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_thread_id    <= id;
        i_priority_req <= prio;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(queue_step(cmd, id, prio));
        items_sent++;
    endtask

    task automatic send_random_item(bit filling);
        logic [CMD_BITS-1:0]              cmd;
        logic [ID_PORT_BITS-1:0]          id;
        logic signed [PRIO_PORT_BITS-1:0] prio;
        int                               roll;
        int                               v;
        roll = $urandom_range(99);
        if (roll < 3)
            cmd = CMD_UNUSED;
        else if (roll < (filling ? 72 : 38))
            cmd = ($urandom_range(99) < 70) ? CMD_INSERT : CMD_APPEND;
        else
            cmd = CMD_POP;
        // a small id pool makes the same-id stop come up often
        id = ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        case ($urandom_range(3))
            0: begin
                v    = int'($urandom_range(6)) - 3;
                prio = v[PRIO_PORT_BITS-1:0];
            end
            3:       prio = ($urandom_range(1) != 0) ? 8'sd127 : -8'sd128;
            default: prio = 8'($urandom_range(255));
        endcase
        send_item(cmd, id, prio);
    endtask

    // sender stops until every result item is back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_item(CMD_POP, 8'hff, 8'sd127);
        send_item(CMD_UNUSED, 8'hff, -8'sd1);
        wait_results_drained();
    endtask

    task automatic test_fill_and_order();
        send_item(CMD_APPEND, 8'd0,   8'sd127);
        send_item(CMD_APPEND, 8'd255, -8'sd128);   // tail regardless of priority
        send_item(CMD_INSERT, 8'd10,  8'sd0);
        send_item(CMD_INSERT, 8'd11,  8'sd0);      // stays behind the equal priority
        send_item(CMD_INSERT, 8'd255, 8'sd127);    // stops at its own id
        send_item(CMD_INSERT, 8'd1,   -8'sd128);
        send_item(CMD_INSERT, 8'd2,   8'sd127);
        send_item(CMD_INSERT, 8'h55,  8'sh55);
        send_item(CMD_INSERT, 8'haa,  -8'sh56);
        send_item(CMD_APPEND, 8'd10,  -8'sd1);
        send_item(CMD_INSERT, 8'd10,  -8'sd1);     // id match near the head
        send_item(CMD_INSERT, 8'd3,   -8'sd128);
        send_item(CMD_INSERT, 8'd4,   8'sd1);
        send_item(CMD_APPEND, 8'd5,   8'sd0);
        send_item(CMD_INSERT, 8'd6,   8'sd126);
        send_item(CMD_INSERT, 8'd7,   -8'sd127);
        wait_results_drained();
    endtask

    task automatic test_overflow();
        send_item(CMD_APPEND, 8'd200, 8'sd5);
        send_item(CMD_INSERT, 8'd201, -8'sd128);
        wait_results_drained();
    endtask

    task automatic test_pop_head();
        send_item(CMD_POP, 8'd0, 8'sd0);
        send_item(CMD_POP, 8'd0, 8'sd0);
        send_item(CMD_UNUSED, 8'd0, 8'sd0);
        send_item(CMD_POP, 8'd0, 8'sd0);
        wait_results_drained();
    endtask

    task automatic test_receiver_holdoff();
        hold_req++;
        repeat (40) send_random_item(1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        bit filling;
        int burst;
        filling = 1'b1;
        burst   = 0;
        while (items_sent < TOTAL_ITEMS) begin
            idle_off = (items_sent >= 500 && items_sent < 700);
            if (items_sent == 900)
                wait_results_drained();
            send_random_item(filling);
            burst++;
            if (burst >= 30) begin
                burst   = 0;
                filling = !filling;
            end
        end
        idle_off = 1'b0;
    endtask

    // receiver: random idling, plus a long hold-off when asked
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= idle_off || ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        t_queue_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_pop_valid, o_popped_id, o_popped_priority, o_entry_count, o_overflow};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item: valid=%0d id=%0d prio=%0d count=%0d ovf=%0d",
                             got.pop_valid, got.popped_id, got.popped_priority,
                             got.entry_count, got.overflow);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected valid=%0d id=%0d prio=%0d count=%0d",
                                  " ovf=%0d, got valid=%0d id=%0d prio=%0d count=%0d ovf=%0d"},
                                 want.pop_valid, want.popped_id, want.popped_priority,
                                 want.entry_count, want.overflow, got.pop_valid,
                                 got.popped_id, got.popped_priority, got.entry_count,
                                 got.overflow);
                end
            end
        end
    end

    initial begin
        int waited;
        mismatches     = 0;
        items_sent     = 0;
        idle_off       = 1'b0;
        hold_req       = 0;
        ready_fill     = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_APPEND;
        i_thread_id    <= '0;
        i_priority_req <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_and_order();
        test_overflow();
        test_pop_head();
        test_receiver_holdoff();
        test_random_traffic();

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 50_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
